// ----- rtl/string_to_int64_parser_core_defines.svh -----
// Assertion macros for the parser RTL.
`ifndef STRING_TO_INT64_PARSER_CORE_DEFINES_SVH
`define STRING_TO_INT64_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i and quiet during reset.
`define STIP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define STIP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/stip_pkg.sv -----
`timescale 1ns / 1ps
package stip_pkg;

  localparam int unsigned PosWidth  = 32;
  localparam int unsigned ClsDepth  = 4;
  localparam int unsigned ClsPtrW   = $clog2(ClsDepth);
  localparam int unsigned ClsCntW   = $clog2(ClsDepth + 1);
  localparam int unsigned ResDepth  = 2;
  localparam int unsigned ResPtrW   = $clog2(ResDepth);
  localparam int unsigned ResCntW   = $clog2(ResDepth + 1);

  localparam logic [5:0] MaxBase    = 6'd36;
  localparam logic [5:0] NoDigit    = 6'd36;
  localparam logic [5:0] BaseHex    = 6'd16;
  localparam logic [5:0] BaseOct    = 6'd8;
  localparam logic [5:0] BaseDec    = 6'd10;
  localparam logic [5:0] BaseBad    = 6'd1;
  localparam logic [7:0] ChLowerX   = 8'h78;
  localparam logic [7:0] ChUpperX   = 8'h58;
  localparam logic [7:0] ChZero     = 8'h30;
  localparam logic [7:0] ChPlus     = 8'h2B;
  localparam logic [7:0] ChMinus    = 8'h2D;
  localparam logic [63:0] SignedMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] EndMax    = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_SPACE  = 6'b000010,
    PH_SIGN   = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_X      = 6'b010000,
    PH_DIGITS = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_BADBASE = 2'd2
  } status_e;

  typedef struct packed {
    logic       first;
    logic       space;
    logic       minus;
    logic       plus;
    logic       zero;
    logic       x;
    logic [5:0] digit;
  } cls_t;

  typedef struct packed {
    logic [63:0] value;
    logic [31:0] end_offset;
    status_e     status;
  } res_t;

endpackage

// ----- rtl/string_to_int64_parser_core.sv -----
`timescale 1ns / 1ps
// Streaming signed 64-bit integer parser, one character per transfer.
// Input queue: drive char_code_i and first_char_i with push while full is low.
// A character with first_char_i high starts a new conversion and drops any
// conversion still open. Each finished conversion gives one result on the output
// queue: value_o, end_offset_o and status_o (0 ok, 1 range, 2 invalid base).
// The oldest result is shown while empty is low and leaves on pop.
// The base is written through cfg_valid_i/cfg_radix_i (cfg_ready_o is always
// high); the user must write it only while the block is idle, as the block
// does not enforce it. It is sampled at each conversion start. Throughput is
// one character per cycle while the result queue is not full, set by the digit
// accumulate step (a 64-by-6 multiply, add and range compare). An ending
// character is registered in the four-entry character queue, its result in the
// two-entry result queue. When the receiver stalls, that queue fills, the
// engine halts, full rises once the character queue fills; nothing is lost.
// Reset empties both queues, returns the engine to idle and sets base 0.
module string_to_int64_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_code_i,
  input  logic               first_char_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [63:0] value_o,
  output logic [31:0]        end_offset_o,
  output logic [1:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [5:0]         cfg_radix_i
);
  import stip_pkg::*;

  logic [5:0] radix_q;
  logic       cls_valid, cls_pop, res_full, res_push;
  cls_t       cls;
  res_t       res_in, res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radix_q <= cfg_radix_i;
    end
  end

  stip_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .char_code_i  (char_code_i),
    .first_char_i (first_char_i),
    .pop_i        (cls_pop),
    .valid_o      (cls_valid),
    .cls_o        (cls)
  );

  stip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radix_i     (radix_q),
    .cls_valid_i (cls_valid),
    .cls_i       (cls),
    .cls_pop_o   (cls_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  stip_res_q u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res_out)
  );

  assign value_o      = res_out.value;
  assign end_offset_o = res_out.end_offset;
  assign status_o     = res_out.status;

endmodule

// ----- rtl/stip_front.sv -----
`timescale 1ns / 1ps
module stip_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [7:0]    char_code_i,
  input  logic          first_char_i,
  input  logic          pop_i,
  output logic          valid_o,
  output stip_pkg::cls_t cls_o
);
  import stip_pkg::*;

  cls_t               mem_q [ClsDepth];
  cls_t               cls_in;
  logic [ClsPtrW-1:0] wr_q, rd_q;
  logic [ClsCntW-1:0] cnt_q, cnt_d;
  logic               wr_en, rd_en;

  always_comb begin
    cls_in.first = first_char_i;
    cls_in.space = (char_code_i == 8'd32) || (char_code_i >= 8'd9 && char_code_i <= 8'd13);
    cls_in.minus = (char_code_i == ChMinus);
    cls_in.plus  = (char_code_i == ChPlus);
    cls_in.zero  = (char_code_i == ChZero);
    cls_in.x     = (char_code_i == ChLowerX) || (char_code_i == ChUpperX);
    if (char_code_i >= 8'h30 && char_code_i <= 8'h39) begin
      cls_in.digit = 6'(char_code_i - 8'h30);
    end else if (char_code_i >= 8'h61 && char_code_i <= 8'h7A) begin
      cls_in.digit = 6'(char_code_i - 8'h61 + 8'd10);
    end else if (char_code_i >= 8'h41 && char_code_i <= 8'h5A) begin
      cls_in.digit = 6'(char_code_i - 8'h41 + 8'd10);
    end else begin
      cls_in.digit = NoDigit;
    end
  end

  assign full_o  = (cnt_q == ClsCntW'(ClsDepth));
  assign valid_o = (cnt_q != '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && valid_o;
  assign cls_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wr_q <= wr_q + 1'b1;
      end
      if (rd_en) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= cls_in;
    end
  end

endmodule

// ----- rtl/stip_back.sv -----
`timescale 1ns / 1ps
`include "string_to_int64_parser_core_defines.svh"
module stip_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [5:0]     radix_i,
  input  logic           cls_valid_i,
  input  stip_pkg::cls_t cls_i,
  output logic           cls_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output stip_pkg::res_t res_o
);
  import stip_pkg::*;

  phase_e              phase_q, phase_d, c_phase;
  logic [5:0]          base_q, base_d, c_base, take_base, begin_base;
  logic                neg_q, neg_d, c_neg;
  logic [63:0]         mag_q, mag_d, c_mag;
  logic                ovf_q, ovf_d, c_ovf;
  logic [PosWidth-1:0] pos_q, pos_d, c_pos;
  logic [PosWidth-1:0] zend_q, zend_d, c_zend;
  logic                adv, start, bad_base, do_begin, do_take, emit;
  logic [63:0]         limit, lim_q, emit_end;
  logic [69:0]         prod;

  function automatic logic [PosWidth-1:0] sat_inc(input logic [PosWidth-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  assign adv       = cls_valid_i && !res_full_i;
  assign cls_pop_o = adv;
  assign start     = cls_i.first;
  assign bad_base  = (radix_i == BaseBad) || (radix_i > MaxBase);

  assign c_phase = start ? PH_SPACE : phase_q;
  assign c_base  = start ? radix_i : base_q;
  assign c_neg   = start ? 1'b0 : neg_q;
  assign c_mag   = start ? '0 : mag_q;
  assign c_ovf   = start ? 1'b0 : ovf_q;
  assign c_pos   = start ? '0 : pos_q;
  assign c_zend  = start ? '0 : zend_q;

  assign limit = SignedMax + 64'(c_neg);
  assign lim_q = SignedMax + 64'(neg_q);

  always_comb begin
    phase_d    = c_phase;
    base_d     = c_base;
    neg_d      = c_neg;
    mag_d      = c_mag;
    ovf_d      = c_ovf;
    zend_d     = c_zend;
    do_begin   = 1'b0;
    do_take    = 1'b0;
    take_base  = c_base;
    begin_base = c_base;
    emit       = 1'b0;
    emit_end   = '0;
    res_o      = '{value: '0, end_offset: '0, status: ST_OK};
    prod       = '0;

    if (start && bad_base) begin
      emit         = 1'b1;
      res_o.status = ST_BADBASE;
      phase_d      = PH_IDLE;
      base_d       = '0;
    end else begin
      case (c_phase)
        PH_SPACE: begin
          if (cls_i.space) begin
            phase_d = PH_SPACE;
          end else if (cls_i.minus) begin
            neg_d   = 1'b1;
            phase_d = PH_SIGN;
          end else if (cls_i.plus) begin
            phase_d = PH_SIGN;
          end else begin
            do_begin = 1'b1;
          end
        end
        PH_SIGN: begin
          do_begin = 1'b1;
        end
        PH_ZERO: begin
          if (cls_i.x) begin
            phase_d = PH_X;
          end else begin
            take_base = (c_base == '0) ? BaseOct : c_base;
            base_d    = take_base;
            do_take   = 1'b1;
          end
        end
        PH_X: begin
          if (cls_i.digit < BaseHex) begin
            take_base = BaseHex;
            base_d    = BaseHex;
            do_take   = 1'b1;
          end else begin
            emit     = 1'b1;
            emit_end = 64'(c_zend);
            phase_d  = PH_IDLE;
          end
        end
        PH_DIGITS: begin
          do_take = 1'b1;
        end
        default: begin
          phase_d = c_phase;
        end
      endcase
    end

    if (do_begin) begin
      if (cls_i.zero && (c_base == '0 || c_base == BaseHex)) begin
        zend_d  = sat_inc(c_pos);
        phase_d = PH_ZERO;
      end else begin
        begin_base = (c_base == '0) ? BaseDec : c_base;
        base_d     = begin_base;
        if (cls_i.digit >= begin_base) begin
          emit    = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          take_base = begin_base;
          do_take   = 1'b1;
        end
      end
    end

    if (do_take) begin
      prod = 70'(c_mag) * 70'(take_base) + 70'(cls_i.digit);
      if (cls_i.digit >= take_base) begin
        emit         = 1'b1;
        emit_end     = 64'(c_pos);
        res_o.value  = c_neg ? (64'd0 - c_mag) : c_mag;
        res_o.status = c_ovf ? ST_RANGE : ST_OK;
        phase_d      = PH_IDLE;
      end else begin
        if (!c_ovf) begin
          if (prod > 70'(limit)) begin
            ovf_d = 1'b1;
            mag_d = limit;
          end else begin
            mag_d = prod[63:0];
          end
        end
        phase_d = PH_DIGITS;
      end
    end

    res_o.end_offset = (emit_end > EndMax) ? '1 : emit_end[31:0];
    pos_d = (phase_d != PH_IDLE) ? sat_inc(c_pos) : c_pos;
  end

  assign res_push_o = adv && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      base_q  <= '0;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      ovf_q   <= 1'b0;
      pos_q   <= '0;
      zend_q  <= '0;
    end else if (adv) begin
      phase_q <= phase_d;
      base_q  <= base_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      ovf_q   <= ovf_d;
      pos_q   <= pos_d;
      zend_q  <= zend_d;
    end
  end

  `STIP_ASSERT(a_badbase_on_start, res_push_o && (res_o.status == ST_BADBASE) |-> cls_i.first, "Invalid base result without a starting character.")
  `STIP_ASSERT(a_ovf_saturated, ovf_q |-> (mag_q == lim_q), "Overflow flag set but magnitude is not saturated.")
  `STIP_ASSERT(a_prefix_clean, (phase_q == PH_SPACE) || (phase_q == PH_SIGN) |-> (mag_q == '0) && !ovf_q, "Magnitude not clear before the first digit.")
  `STIP_ASSERT_NXT(a_badbase_idle, adv && cls_i.first && bad_base, phase_q == PH_IDLE, "Invalid base did not end the conversion.")

endmodule

// ----- rtl/stip_res_q.sv -----
`timescale 1ns / 1ps
module stip_res_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  stip_pkg::res_t res_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output stip_pkg::res_t res_o
);
  import stip_pkg::*;

  res_t               mem_q [ResDepth];
  logic [ResPtrW-1:0] wr_q, rd_q;
  logic [ResCntW-1:0] cnt_q, cnt_d;
  logic               wr_en, rd_en;

  assign full_o  = (cnt_q == ResCntW'(ResDepth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign res_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wr_q <= wr_q + 1'b1;
      end
      if (rd_en) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= res_i;
    end
  end

endmodule
